// ===== rtl/fupd_pkg.sv =====
// Shared types, constants and helpers for the file URL / path percent decoder.
// Used by fupd_step and file_url_path_percent_decoder_unit; no dependencies.
`default_nettype none

package fupd_pkg;

  localparam int unsigned SchemeLen = 7;

  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] CaseBit   = 8'h20;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_PREFIX = 3'd1,
    PH_HOST   = 3'd2,
    PH_PATH   = 3'd3,
    PH_REJECT = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_DIG  = 2'd2
  } esc_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] pos;
    esc_t       esc;
    logic [7:0] held;
  } fupd_state_t;

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
    logic       is_err;
  } res_t;

  localparam fupd_state_t StateReset = '{phase: PH_START, pos: 3'd0, esc: ESC_NONE,
                                         held: 8'd0};

  // Bytes of "file://" by position.
  function automatic logic [7:0] scheme_byte(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h66;  // f
      3'd1:    c = 8'h69;  // i
      3'd2:    c = 8'h6C;  // l
      3'd3:    c = 8'h65;  // e
      3'd4:    c = 8'h3A;  // :
      3'd5:    c = 8'h2F;  // /
      3'd6:    c = 8'h2F;  // /
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | CaseBit;
    return ((c >= 8'h30) && (c <= 8'h39)) || ((lc >= 8'h61) && (lc <= 8'h66));
  endfunction

  // Digits map straight from the low nibble; letters a..f have low nibble 1..6.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    if (c <= 8'h39) v = c[3:0];
    else            v = c[3:0] + 4'd9;
    return v;
  endfunction

  function automatic res_t mk_res(input logic [7:0] value);
    res_t r;
    r.value   = value;
    r.is_last = 1'b0;
    r.is_err  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fupd_step.sv =====
// Next-state and result logic for one input byte of the percent decoder.
// Purely combinational; depends on fupd_pkg.
`default_nettype none

module fupd_step import fupd_pkg::*; (
  input  fupd_state_t       st_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output fupd_state_t       st_o,
  output logic [1:0]        cnt_o,
  output res_t [2:0]        res_o
);

  always_comb begin
    fupd_state_t s;
    logic [1:0]  n;
    res_t [2:0]  r;
    logic        do_path;
    logic        fresh;

    s       = st_i;
    n       = 2'd0;
    r       = '0;
    do_path = 1'b0;
    fresh   = 1'b0;

    unique case (st_i.phase)
      PH_START: begin
        if (byte_i == ChSlash) begin
          s.phase = PH_PATH;
          do_path = 1'b1;
        end else if (byte_i == scheme_byte(3'd0)) begin
          s.phase = PH_PREFIX;
          s.pos   = 3'd1;
        end else begin
          s.phase = PH_REJECT;
        end
      end
      PH_PREFIX: begin
        if ((st_i.pos < 3'(SchemeLen)) && (byte_i == scheme_byte(st_i.pos))) begin
          s.pos = st_i.pos + 3'd1;
          if (s.pos == 3'(SchemeLen)) s.phase = PH_HOST;
        end else begin
          s.phase = PH_REJECT;
        end
      end
      PH_HOST: begin
        if (byte_i == ChSlash) begin
          s.phase = PH_PATH;
          do_path = 1'b1;
        end
      end
      PH_PATH: do_path = 1'b1;
      default: s.phase = PH_REJECT;
    endcase

    if (do_path) begin
      case (s.esc)
        ESC_PCT: begin
          if (is_hex(byte_i)) begin
            s.held = byte_i;
            s.esc  = ESC_DIG;
          end else begin
            r[n]  = mk_res(ChPercent);
            n     = n + 2'd1;
            s.esc = ESC_NONE;
            fresh = 1'b1;
          end
        end
        ESC_DIG: begin
          if (is_hex(byte_i)) begin
            r[n]   = mk_res({hex_nibble(s.held), hex_nibble(byte_i)});
            n      = n + 2'd1;
            s.esc  = ESC_NONE;
            s.held = 8'd0;
          end else begin
            r[n]   = mk_res(ChPercent);
            n      = n + 2'd1;
            r[n]   = mk_res(s.held);
            n      = n + 2'd1;
            s.esc  = ESC_NONE;
            s.held = 8'd0;
            fresh  = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase
      // The byte that broke an escape is a new path byte.
      if (fresh) begin
        if (byte_i == ChPercent) begin
          s.esc = ESC_PCT;
        end else begin
          r[n] = mk_res(byte_i);
          n    = n + 2'd1;
        end
      end
    end

    if (last_i) begin
      if (s.phase == PH_PATH) begin
        // Flush an unfinished escape literally.
        if (s.esc == ESC_PCT) begin
          r[n] = mk_res(ChPercent);
          n    = n + 2'd1;
        end else if (s.esc == ESC_DIG) begin
          r[n] = mk_res(ChPercent);
          n    = n + 2'd1;
          r[n] = mk_res(s.held);
          n    = n + 2'd1;
        end
        if (n != 2'd0) r[n - 2'd1].is_last = 1'b1;
      end else begin
        r            = '0;
        r[0].is_last = 1'b1;
        r[0].is_err  = 1'b1;
        n            = 2'd1;
      end
      s = StateReset;
    end

    st_o  = s;
    cnt_o = n;
    res_o = r;
  end

endmodule

`default_nettype wire

// ===== rtl/file_url_path_percent_decoder_unit.sv =====
// Top level of the file URL / path percent decoder: input skid register,
// decode step and a three-entry result queue. Depends on fupd_pkg, fupd_step.
// A byte waits in the input register until the queue takes its results.
// Throughput: one byte per cycle while each byte gives at most one result
// and the output is ready; k results of one byte hold the queue until taken.
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to "awaiting the first byte of a string".
`default_nettype none

module file_url_path_percent_decoder_unit import fupd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // in_last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast,  // out_last
  output logic            out_tuser   // [0] out_error
);

  // Input register: holds one request so the input side keeps moving
  // while a finished result still waits at the output.
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Decoder state, advanced once per processed byte.
  fupd_state_t st_r;
  fupd_state_t st_nxt;

  // Result queue: entry 0 is presented, the rest shift down as it drains.
  res_t [2:0] q_r;
  logic [1:0] q_cnt_r;

  logic [1:0] step_cnt;
  res_t [2:0] step_res;

  logic in_acc;
  logic out_acc;
  logic q_free;
  logic advance;

  fupd_step u_step (
    .st_i   (st_r),
    .byte_i (in_byte_r),
    .last_i (in_last_r),
    .st_o   (st_nxt),
    .cnt_o  (step_cnt),
    .res_o  (step_res)
  );

  assign out_acc = out_tvalid && out_tready;
  // The queue takes a new batch when empty or when its last entry leaves now.
  assign q_free  = (q_cnt_r == 2'd0) || ((q_cnt_r == 2'd1) && out_tready);
  assign advance = in_vld_r && q_free;

  assign in_tready = !in_vld_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  // Input register: load on accept, drop once processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Decoder state advances with each processed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StateReset;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result queue count: load a batch, or count down as results leave.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else if (advance) begin
      q_cnt_r <= step_cnt;
    end else if (out_acc) begin
      q_cnt_r <= q_cnt_r - 2'd1;
    end
  end

  // Result payload: load the batch, otherwise shift down on each transfer.
  always_ff @(posedge clk) begin
    if (advance) begin
      q_r <= step_res;
    end else if (out_acc) begin
      q_r[0] <= q_r[1];
      q_r[1] <= q_r[2];
    end
  end

  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tdata  = q_r[0].value;
  assign out_tlast  = q_r[0].is_last;
  assign out_tuser  = q_r[0].is_err;

endmodule

`default_nettype wire
